@@ rtl/core/pixel_store_with_hsb_convert_macros.svh @@
// ----------------------------------------------------------------------------
// Pixel store assertion macros
// Concurrent assertion wrappers used by the pixel store back end. Defining
// ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef PIXEL_STORE_WITH_HSB_CONVERT_MACROS_SVH
`define PIXEL_STORE_WITH_HSB_CONVERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checks that prop holds at every rising clock edge outside reset.
`define PSH_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
// Checks that expr is never true outside reset.
`define PSH_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define PSH_ASSERT(name, clk, rst, prop)
`define PSH_NEVER(name, clk, rst, expr)
`endif
`endif

@@ rtl/core/psh_pkg.sv @@
// ----------------------------------------------------------------------------
// Pixel store package
// Types, command codes and conversion constants shared by the pixel store.
// ----------------------------------------------------------------------------
`default_nettype none

package psh_pkg;

   localparam int unsigned MAX_PIXELS_DEFAULT = 1024;

   // Command queue between the front and back ends.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   // Wide enough for any chain length or pixel count in the parameter range.
   localparam int unsigned EXT_W = 17;

   localparam int unsigned HUE_MAX     = 360;
   localparam int unsigned HUE_SECTOR  = 120;
   localparam int unsigned HUE_SECTOR2 = 240;
   localparam int unsigned WEIGHT_MAX  = 60;
   localparam int unsigned CHAN_MAX    = 255;

   // Channel value is base plus floor(n / 15300); the quotient is estimated
   // with a reciprocal and then corrected by at most one.
   localparam int unsigned HSB_DIV   = 15300;
   localparam int unsigned HSB_SHIFT = 32;
   localparam logic [18:0] HSB_RECIP = 19'((64'd1 << HSB_SHIFT) / 64'(HSB_DIV));

   typedef enum logic [1:0] {
      OP_WRITE_RGB = 2'd0,
      OP_WRITE_HSB = 2'd1,
      OP_CLEAR     = 2'd2,
      OP_READ      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_HSB,
      BK_CLEAR,
      BK_READ
   } back_state_type;

   typedef enum logic [1:0] {
      PH_WEIGHT,
      PH_SCALE,
      PH_RECIP,
      PH_FIX
   } hsb_phase_type;

   // Per-channel sector distances (red, green, blue), saturation, and the
   // lightness blend split into a multiplier and an additive base.
   typedef struct packed {
      logic [2:0][6:0] sector_dist;
      logic [7:0]      sat;
      logic [6:0]      mult;
      logic [7:0]      base;
   } hsb_req_type;

   typedef struct packed {
      op_type      op;
      logic        hit;
      logic [9:0]  pixel_index;
      logic [23:0] color_word;
      hsb_req_type hsb;
   } cmd_type;

endpackage

`default_nettype wire

@@ rtl/core/psh_front.sv @@
// ----------------------------------------------------------------------------
// Pixel store front end
// Holds the chain length register, classifies incoming commands and queues
// them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module psh_front #(
   parameter int unsigned MAX_PIXELS = psh_pkg::MAX_PIXELS_DEFAULT,
   localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic [10:0]      csr_write_data,
   input  wire logic             req_push,
   output      logic             req_full,
   input  wire logic [1:0]       req_opcode,
   input  wire logic [9:0]       req_pixel_index,
   input  wire logic [23:0]      req_color_word,
   input  wire logic [8:0]       req_hue,
   input  wire logic [7:0]       req_saturation,
   input  wire logic [7:0]       req_level,
   output      logic [CNT_W-1:0] count_o,
   output      psh_pkg::cmd_type head_o,
   output      logic             head_valid_o,
   input  wire logic             pop_i
);
   import psh_pkg::*;

   logic [10:0]       chain_length_ff;
   logic [EXT_W-1:0]  len_ext;
   logic [EXT_W-1:0]  max_ext;
   logic [EXT_W-1:0]  cnt_ext;
   logic [8:0]        hue_c;
   logic [8:0]        dr;
   logic [8:0]        dg;
   logic [8:0]        db;
   cmd_type           cmd;
   cmd_type           queue_mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   fill_ff;
   logic              push_ok;
   logic              pop_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_length_ff <= '0;
      end else if (csr_write_enable) begin
         chain_length_ff <= csr_write_data;
      end
   end

   // Pixels in use are those below both the chain length and the memory depth.
   assign len_ext = EXT_W'(chain_length_ff);
   assign max_ext = EXT_W'(MAX_PIXELS);
   assign cnt_ext = (len_ext < max_ext) ? len_ext : max_ext;
   assign count_o = cnt_ext[CNT_W-1:0];

   // Hue sector distances.
   always_comb begin
      hue_c = (req_hue > 9'(HUE_MAX)) ? 9'(HUE_MAX) : req_hue;
      if (hue_c < 9'(HUE_SECTOR)) begin
         dr = 9'(HUE_SECTOR) - hue_c;
         dg = hue_c;
         db = '0;
      end else if (hue_c < 9'(HUE_SECTOR2)) begin
         dr = '0;
         dg = 9'(HUE_SECTOR2) - hue_c;
         db = hue_c - 9'(HUE_SECTOR);
      end else begin
         dr = hue_c - 9'(HUE_SECTOR2);
         dg = '0;
         db = 9'(HUE_MAX) - hue_c;
      end
   end

   always_comb begin
      cmd.op                 = op_type'(req_opcode);
      cmd.hit                = EXT_W'(req_pixel_index) < cnt_ext;
      cmd.pixel_index        = req_pixel_index;
      cmd.color_word         = req_color_word;
      cmd.hsb.sector_dist[0] = dr[6:0];
      cmd.hsb.sector_dist[1] = dg[6:0];
      cmd.hsb.sector_dist[2] = db[6:0];
      cmd.hsb.sat            = req_saturation;
      // In the upper half the lightness blend is (255-L)*C/15300 plus 2L-255,
      // and both pieces fit in the low seven bits of the level.
      if (req_level[7]) begin
         cmd.hsb.mult = ~req_level[6:0];
         cmd.hsb.base = {req_level[6:0], 1'b1};
      end else begin
         cmd.hsb.mult = req_level[6:0];
         cmd.hsb.base = '0;
      end
   end

   assign req_full     = (fill_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign head_valid_o = (fill_ff != '0);
   assign head_o       = queue_mem[rd_ptr_ff];
   assign push_ok      = req_push && !req_full;
   assign pop_ok       = pop_i && head_valid_o;

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_mem[wr_ptr_ff] <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push_ok && !pop_ok) begin
            fill_ff <= fill_ff + (QPTR_W + 1)'(1);
         end else if (pop_ok && !push_ok) begin
            fill_ff <= fill_ff - (QPTR_W + 1)'(1);
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/psh_hsb.sv @@
// ----------------------------------------------------------------------------
// Pixel store HSB converter
// Converts one hue/saturation/level request to packed RGB, one channel at a
// time, four steps per channel.
// ----------------------------------------------------------------------------
`default_nettype none

module psh_hsb (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start_i,
   input  wire psh_pkg::hsb_req_type req_i,
   output      logic                 done_o,
   output      logic [23:0]          rgb_o
);
   import psh_pkg::*;

   hsb_phase_type   phase_ff;
   hsb_phase_type   phase_in;
   logic [1:0]      chan_ff;
   logic [1:0]      chan_in;
   logic            busy_ff;
   logic            busy_in;
   logic            done_ff;
   logic            done_in;
   hsb_req_type     req_ff;
   logic [2:0][7:0] rgb_ff;
   logic [14:0]     c_ff;
   logic [21:0]     n_ff;
   logic [7:0]      q0_ff;
   logic [6:0]      dist_sel;
   logic [5:0]      weight;
   logic [15:0]      sat_w;
   logic [15:0]     c_calc;
   logic [40:0]     recip_prod;
   logic [21:0]     q_back;
   logic [21:0]     rem;
   logic [7:0]      q_fix;
   logic [7:0]      chan_val;

   assign dist_sel = req_ff.sector_dist[chan_ff];
   assign weight   = (dist_sel > 7'(WEIGHT_MAX)) ? 6'(WEIGHT_MAX) : dist_sel[5:0];
   assign sat_w    = 16'(req_ff.sat) * 16'(weight);
   assign c_calc   = (sat_w << 1)
                   + 16'(WEIGHT_MAX) * 16'(8'(CHAN_MAX) - req_ff.sat);

   assign recip_prod = 41'(n_ff) * 41'(HSB_RECIP);

   // The reciprocal estimate is at most one short of the true quotient.
   assign q_back   = 22'(q0_ff) * 22'(HSB_DIV);
   assign rem      = n_ff - q_back;
   assign q_fix    = q0_ff + 8'(rem >= 22'(HSB_DIV));
   assign chan_val = req_ff.base + q_fix;

   always_comb begin
      phase_in = phase_ff;
      chan_in  = chan_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (!busy_ff) begin
         if (start_i) begin
            busy_in  = 1'b1;
            phase_in = PH_WEIGHT;
            chan_in  = '0;
         end
      end else begin
         case (phase_ff)
            PH_WEIGHT: phase_in = PH_SCALE;
            PH_SCALE:  phase_in = PH_RECIP;
            PH_RECIP:  phase_in = PH_FIX;
            PH_FIX: begin
               phase_in = PH_WEIGHT;
               if (chan_ff == 2'd2) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
                  chan_in = '0;
               end else begin
                  chan_in = chan_ff + 2'd1;
               end
            end
            default: phase_in = PH_WEIGHT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WEIGHT;
         chan_ff  <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         chan_ff  <= chan_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!busy_ff && start_i) begin
         req_ff <= req_i;
      end
      if (busy_ff) begin
         case (phase_ff)
            PH_WEIGHT: c_ff <= c_calc[14:0];
            PH_SCALE:  n_ff <= 22'(req_ff.mult) * 22'(c_ff);
            PH_RECIP:  q0_ff <= recip_prod[HSB_SHIFT+7:HSB_SHIFT];
            PH_FIX:    rgb_ff[chan_ff] <= chan_val;
            default:   c_ff <= c_ff;
         endcase
      end
   end

   assign done_o = done_ff;
   assign rgb_o  = {rgb_ff[2], rgb_ff[1], rgb_ff[0]};

endmodule

`default_nettype wire

@@ rtl/core/psh_back.sv @@
// ----------------------------------------------------------------------------
// Pixel store back end
// Executes queued commands against the pixel memory: writes, clear sweep,
// HSB write-back and reads into a one-deep result slot.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pixel_store_with_hsb_convert_macros.svh"

module psh_back #(
   parameter int unsigned MAX_PIXELS = psh_pkg::MAX_PIXELS_DEFAULT,
   localparam int unsigned CNT_W  = $clog2(MAX_PIXELS + 1),
   localparam int unsigned ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CNT_W-1:0] count_i,
   input  wire psh_pkg::cmd_type head_i,
   input  wire logic             head_valid_i,
   output      logic             pop_o,
   output      logic             hsb_start_o,
   input  wire logic             hsb_done_i,
   input  wire logic [23:0]      hsb_rgb_i,
   output      logic             rsp_empty,
   input  wire logic             rsp_pop,
   output      logic [23:0]      rsp_read_color,
   output      logic             rsp_in_range
);
   import psh_pkg::*;

   back_state_type    state_ff;
   back_state_type    state_in;
   logic [CNT_W-1:0]  cursor_ff;
   logic [CNT_W-1:0]  cursor_in;
   logic [CNT_W-1:0]  cursor_next;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] addr_in;
   logic [EXT_W-1:0]  idx_ext;
   logic [ADDR_W-1:0] head_addr;
   logic [23:0]       pixel_mem [MAX_PIXELS];
   logic [23:0]       mem_q_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [23:0]       mem_wdata;
   logic              out_valid_ff;
   logic [23:0]       out_color_ff;
   logic              out_in_range_ff;
   logic              out_load;
   logic [23:0]       load_color;
   logic              load_in_range;

   assign idx_ext     = EXT_W'(head_i.pixel_index);
   assign head_addr   = idx_ext[ADDR_W-1:0];
   assign cursor_next = cursor_ff + CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      addr_in       = addr_ff;
      pop_o         = 1'b0;
      hsb_start_o   = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = head_addr;
      mem_wdata     = head_i.color_word;
      out_load      = 1'b0;
      load_color    = '0;
      load_in_range = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (head_valid_i) begin
               case (head_i.op)
                  OP_WRITE_RGB: begin
                     pop_o  = 1'b1;
                     mem_we = head_i.hit;
                  end
                  OP_WRITE_HSB: begin
                     pop_o = 1'b1;
                     if (head_i.hit) begin
                        hsb_start_o = 1'b1;
                        addr_in     = head_addr;
                        state_in    = BK_HSB;
                     end
                  end
                  OP_CLEAR: begin
                     pop_o = 1'b1;
                     if (count_i != '0) begin
                        state_in = BK_CLEAR;
                     end
                  end
                  OP_READ: begin
                     // A read waits until the result slot is free.
                     if (!out_valid_ff) begin
                        pop_o = 1'b1;
                        if (head_i.hit) begin
                           state_in = BK_READ;
                        end else begin
                           out_load = 1'b1;
                        end
                     end
                  end
                  default: pop_o = 1'b1;
               endcase
            end
         end
         BK_HSB: begin
            if (hsb_done_i) begin
               mem_we    = 1'b1;
               mem_waddr = addr_ff;
               mem_wdata = hsb_rgb_i;
               state_in  = BK_IDLE;
            end
         end
         BK_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cursor_ff[ADDR_W-1:0];
            mem_wdata = '0;
            if (cursor_next == count_i) begin
               cursor_in = '0;
               state_in  = BK_IDLE;
            end else begin
               cursor_in = cursor_next;
            end
         end
         BK_READ: begin
            out_load      = 1'b1;
            load_color    = mem_q_ff;
            load_in_range = 1'b1;
            state_in      = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         cursor_ff <= '0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= pixel_mem[head_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop && out_valid_ff) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_color_ff    <= load_color;
         out_in_range_ff <= load_in_range;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_read_color = out_color_ff;
   assign rsp_in_range   = out_in_range_ff;

   `PSH_ASSERT(a_read_slot_free, clock, reset, (state_ff == BK_READ) |-> !out_valid_ff)
   `PSH_ASSERT(a_cursor_parked, clock, reset, (state_ff != BK_CLEAR) |-> (cursor_ff == '0))
   `PSH_ASSERT(a_cursor_bound, clock, reset, (state_ff == BK_CLEAR) |-> (cursor_ff < count_i))
   `PSH_NEVER(a_done_unexpected, clock, reset, hsb_done_i && (state_ff != BK_HSB))

endmodule

`default_nettype wire

@@ rtl/core/pixel_store_with_hsb_convert.sv @@
// ----------------------------------------------------------------------------
// Pixel store with HSB conversion
// Pixel memory for an LED chain, written as packed RGB or as hue/saturation/
// level, cleared as a whole and read back one pixel at a time.
// ----------------------------------------------------------------------------
// Commands enter a four-deep queue and are executed one at a time by the back
// end. A write-RGB is done directly from the idle state. A read waits for the
// result slot, which holds one transaction, and a hit then loads it from the
// registered memory word. For a write-HSB the converter works one color
// channel at a time in four steps (weight, scale, reciprocal multiply,
// correction). A clear writes one pixel per cycle through the single memory
// write port. Only pixels below both the chain length and MAX_PIXELS are
// written or read; a read outside them returns zero with in_range low. There
// is no clearing pass after reset: read only pixels that were written or
// cleared.
`default_nettype none

module pixel_store_with_hsb_convert #(
   parameter int unsigned MAX_PIXELS = psh_pkg::MAX_PIXELS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [10:0] csr_write_data,
   input  wire logic        req_push,
   output      logic        req_full,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [9:0]  req_pixel_index,
   input  wire logic [23:0] req_color_word,
   input  wire logic [8:0]  req_hue,
   input  wire logic [7:0]  req_saturation,
   input  wire logic [7:0]  req_level,
   output      logic        rsp_empty,
   input  wire logic        rsp_pop,
   output      logic [23:0] rsp_read_color,
   output      logic        rsp_in_range
);
   import psh_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);

   logic [CNT_W-1:0] pixel_count;
   cmd_type          head;
   logic             head_valid;
   logic             head_pop;
   logic             hsb_start;
   logic             hsb_done;
   logic [23:0]      hsb_rgb;

   psh_front #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_opcode       (req_opcode),
      .req_pixel_index  (req_pixel_index),
      .req_color_word   (req_color_word),
      .req_hue          (req_hue),
      .req_saturation   (req_saturation),
      .req_level        (req_level),
      .count_o          (pixel_count),
      .head_o           (head),
      .head_valid_o     (head_valid),
      .pop_i            (head_pop)
   );

   psh_hsb u_hsb (
      .clock   (clock),
      .reset   (reset),
      .start_i (hsb_start),
      .req_i   (head.hsb),
      .done_o  (hsb_done),
      .rgb_o   (hsb_rgb)
   );

   psh_back #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .count_i        (pixel_count),
      .head_i         (head),
      .head_valid_i   (head_valid),
      .pop_o          (head_pop),
      .hsb_start_o    (hsb_start),
      .hsb_done_i     (hsb_done),
      .hsb_rgb_i      (hsb_rgb),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_read_color (rsp_read_color),
      .rsp_in_range   (rsp_in_range)
   );

endmodule

`default_nettype wire
